// ----- rtl/core/dsac_pkg.sv -----
// Shared types and constants for the door sequence alarm controller.
package dsac_pkg;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned COUNT_W     = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_DELAY  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OPENINGS    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF     = 2'd3;

  localparam logic [31:0]        OPEN_WINDOW_RST = 32'd10000;
  localparam logic [31:0]        SCAN_DELAY_RST  = 32'd10000;
  localparam logic [COUNT_W-1:0] OPENINGS_RST    = 4'd5;
  localparam logic [15:0]        HOLDOFF_RST     = 16'd500;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [31:0]        open_window_ms;
    logic [31:0]        scan_delay_ms;
    logic [COUNT_W-1:0] openings_for_config;
    logic [15:0]        holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic        door_is_open;
    logic [31:0] now_ms;
    logic        settings_valid;
    logic        link_connected;
  } in_item_t;

  typedef struct packed {
    logic alarm;
    logic alarm_inhibited;
    logic blink_request;
    logic mode_now;
    logic opened_edge;
    logic closed_edge;
    logic sample_ignored;
  } out_item_t;

endpackage

// ----- rtl/core/door_sequence_alarm_controller.sv -----
// Top level of the door sequence alarm controller: input register, step logic, result register.
//
// Usage: each input item is one door sensor sample with the current time in ms,
// a settings-valid flag and a link-connected flag, sent on in_valid/in_ready.
// Every item gives exactly one result item on out_valid/out_ready carrying the
// alarm, inhibited alarm, blink request, current mode and edge/hold-off flags.
// An accepted item sits in the input register, is evaluated by the step logic
// and written to the result register, and is taken from there by the receiver.
// One item per cycle is sustained while out_ready stays high; the state update
// in the step logic (time compares plus one add and compare on the reopen
// window) is combinational and written to the state registers on advance.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_ready then drops until out_ready returns.
// Reset clears the mode to normal, the door to closed, the open count and all
// stored times, and loads the register defaults. Configuration writes on
// cfg_wr_en take effect at once and are meant for idle periods only.
module door_sequence_alarm_controller #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dsac_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dsac_pkg::out_item_t              out_item,
  input  logic                             cfg_wr_en,
  input  logic [dsac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dsac_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;

  dsac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dsac_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .item    (s1_item_r),
    .result  (result)
  );

  // Move the held item into the result register whenever that slot frees up
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_alarm_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.alarm && out_item.alarm_inhibited))
    else $error("alarm and inhibited alarm both set");

  a_blink_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.blink_request == (out_item.alarm || out_item.alarm_inhibited)))
    else $error("blink request does not match presence check");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.sample_ignored) |->
      !(out_item.blink_request || out_item.opened_edge || out_item.closed_edge))
    else $error("ignored sample produced activity");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

// ----- rtl/core/dsac_cfg_regs.sv -----
// Configuration register file with write-only port.
module dsac_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [dsac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dsac_pkg::cfg_t                   cfg
);
  import dsac_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_window_ms      <= OPEN_WINDOW_RST;
      cfg_r.scan_delay_ms       <= SCAN_DELAY_RST;
      cfg_r.openings_for_config <= OPENINGS_RST;
      cfg_r.holdoff_ms          <= HOLDOFF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OPEN_WINDOW: cfg_r.open_window_ms      <= cfg_wdata;
        REG_SCAN_DELAY:  cfg_r.scan_delay_ms       <= cfg_wdata;
        REG_OPENINGS:    cfg_r.openings_for_config <= cfg_wdata[COUNT_W-1:0];
        REG_HOLDOFF:     cfg_r.holdoff_ms          <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/dsac_step.sv -----
// Door sequence state registers and the per-item next-state and result logic.
module dsac_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  dsac_pkg::cfg_t      cfg,
  input  dsac_pkg::in_item_t  item,
  output dsac_pkg::out_item_t result
);
  import dsac_pkg::*;

  logic                 last_door_r, last_door_nxt;
  logic                 mode_r, mode_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [TIME_BITS-1:0] first_r, first_nxt;
  logic [TIME_BITS-1:0] scan_r, scan_nxt;
  logic [TIME_BITS-1:0] hold_r, hold_nxt;

  // Time operands brought to TIME_BITS: zero-extend, then keep the low bits
  logic [TIME_BITS+31:0] now_ext, window_ext, delay_ext;
  logic [TIME_BITS+15:0] holdoff_ext;
  logic [TIME_BITS-1:0]  now_t, window_t, delay_t, holdoff_t, window_end;

  logic alarm, inhibited, blink, opened, closed, ignored;

  assign now_ext     = {{TIME_BITS{1'b0}}, item.now_ms};
  assign window_ext  = {{TIME_BITS{1'b0}}, cfg.open_window_ms};
  assign delay_ext   = {{TIME_BITS{1'b0}}, cfg.scan_delay_ms};
  assign holdoff_ext = {{TIME_BITS{1'b0}}, cfg.holdoff_ms};
  assign now_t       = now_ext[TIME_BITS-1:0];
  assign window_t    = window_ext[TIME_BITS-1:0];
  assign delay_t     = delay_ext[TIME_BITS-1:0];
  assign holdoff_t   = holdoff_ext[TIME_BITS-1:0];
  assign window_end  = first_r + window_t;

  always_comb begin
    last_door_nxt = last_door_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    first_nxt     = first_r;
    scan_nxt      = scan_r;
    hold_nxt      = hold_r;
    alarm         = 1'b0;
    inhibited     = 1'b0;
    blink         = 1'b0;
    opened        = 1'b0;
    closed        = 1'b0;
    ignored       = 1'b0;

    if (now_t < hold_r) begin
      ignored = 1'b1;
    end else begin
      // Presence check due: blink, drop the count, alarm unless the link is up
      if (now_t > scan_r && !mode_r && count_r != '0) begin
        blink     = 1'b1;
        count_nxt = '0;
        if (item.link_connected) begin
          inhibited = 1'b1;
        end else begin
          alarm = 1'b1;
        end
      end
      if (item.door_is_open != last_door_r) begin
        last_door_nxt = item.door_is_open;
        if (item.door_is_open) begin
          opened = 1'b1;
          if (count_nxt != '0 && now_t < window_end) begin
            if (count_nxt != COUNT_MAX) begin
              count_nxt = count_nxt + 1'b1;
            end
          end else begin
            count_nxt = 4'd1;
            first_nxt = now_t;
          end
          if (count_nxt >= cfg.openings_for_config && !mode_r) begin
            count_nxt = '0;
            mode_nxt  = 1'b1;
          end else if (!mode_r) begin
            scan_nxt = now_t + delay_t;
          end
        end else begin
          closed = 1'b1;
          if (mode_r && item.settings_valid) begin
            count_nxt = '0;
            mode_nxt  = 1'b0;
          end
        end
        hold_nxt = now_t + holdoff_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_door_r <= 1'b0;
      mode_r      <= 1'b0;
      count_r     <= '0;
      first_r     <= '0;
      scan_r      <= '0;
      hold_r      <= '0;
    end else if (advance) begin
      last_door_r <= last_door_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      first_r     <= first_nxt;
      scan_r      <= scan_nxt;
      hold_r      <= hold_nxt;
    end
  end

  assign result.alarm           = alarm;
  assign result.alarm_inhibited = inhibited;
  assign result.blink_request   = blink;
  assign result.mode_now        = mode_nxt;
  assign result.opened_edge     = opened;
  assign result.closed_edge     = closed;
  assign result.sample_ignored  = ignored;

endmodule
